@@ rtl/bdlec_pkg.sv @@
// Package for the button-driven LED effect controller.
// Holds mode and register-index codes, field widths, reset values and limits.
// No dependencies.
`default_nettype none

package bdlec_pkg;

  // Field widths
  localparam int unsigned NumBtn      = 7;
  localparam int unsigned GroupCount  = 5;
  localparam int unsigned ResetBit    = 6;
  localparam int unsigned QuietW      = 11;
  localparam int unsigned SinceW      = 13;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 24;

  // Counter limits and breathing constants
  localparam logic [QuietW-1:0] QuietMax      = '1;
  localparam logic [SinceW-1:0] SinceMax      = '1;
  localparam logic [7:0]        PeakFull      = 8'd255;
  localparam logic [7:0]        PeakPerButton = 8'd51;

  // Configuration reset values
  localparam logic [9:0]  DebounceRst    = 10'd50;
  localparam logic [9:0]  BreatheIntRst  = 10'd20;
  localparam logic [7:0]  BreatheStepRst = 8'd5;
  localparam logic [12:0] BlinkIntRst    = 13'd250;
  localparam logic [23:0] RedColorRst    = 24'hFF0000;
  localparam logic [23:0] GreenColorRst  = 24'h00FF00;
  localparam logic [23:0] FlashColorRst  = 24'hFFA500;

  typedef enum logic [1:0] {
    MODE_RED   = 2'd0,
    MODE_GREEN = 2'd1,
    MODE_FLASH = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE     = 3'd0,
    REG_BREATHE_INT  = 3'd1,
    REG_BREATHE_STEP = 3'd2,
    REG_BLINK_INT    = 3'd3,
    REG_RED_COLOR    = 3'd4,
    REG_GREEN_COLOR  = 3'd5,
    REG_FLASH_COLOR  = 3'd6
  } reg_idx_e;

endpackage

`default_nettype wire

@@ rtl/button_driven_led_effect_controller.sv @@
// Top level of the button-driven LED effect controller.
// Depends on bdlec_pkg (codes, widths, reset values).
`default_nettype none

// One input transfer is one millisecond tick carrying seven raw active-low
// button levels (bit 0 warning, bits 1..5 group, bit 6 reset). Each tick
// produces exactly one result. The block is a two-stage pipeline and takes
// a new tick in every clock cycle unless in_stall_o is high: stage one
// debounces the buttons, steps the effect of the mode held from the
// previous tick (red breathing, green breathing, yellow flashing) and runs
// the priority logic that picks the next mode and raises the one-shot
// events; stage two scales the effect colour by brightness/255 with three
// 8x8 multipliers and holds the result in the output register, which
// follows the stage-one register. in_stall_o rises only when both stages
// hold items and the output is stalled. The configuration port is always
// ready; write it only while no tick is in flight.
module button_driven_led_effect_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // tick input
  input  wire logic                              in_valid_i,
  output      logic                              in_stall_o,
  input  wire logic [6:0]                        raw_levels_i,
  // result output
  output      logic                              out_valid_o,
  input  wire logic                              out_stall_i,
  output      logic [7:0]                        led_red_o,
  output      logic [7:0]                        led_green_o,
  output      logic [7:0]                        led_blue_o,
  output      logic                              strip_refresh_o,
  output      logic [6:0]                        pressed_mask_o,
  output      logic [1:0]                        effect_mode_o,
  output      logic                              reset_event_o,
  output      logic                              all_group_event_o,
  output      logic                              first_press_event_o,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [bdlec_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [bdlec_pkg::CfgDataW-1:0]    cfg_data_i
);

  // Stage-one result: everything but the colour scaling
  typedef struct packed {
    logic        refresh;
    logic        scaled;    // 1: rgb * bright / 255, 0: push rgb as is
    logic [7:0]  bright;
    logic [23:0] rgb;
    logic [6:0]  pressed;
    logic [1:0]  mode;
    logic        ev_reset;
    logic        ev_all;
    logic        ev_first;
  } s1_t;

  function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = c * b;
    // exact divide by 255 for a 16-bit product
    sum = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [9:0]  debounce_q, breathe_int_q;
  logic [7:0]  breathe_step_q;
  logic [12:0] blink_int_q;
  logic [23:0] red_color_q, green_color_q, flash_color_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= bdlec_pkg::DebounceRst;
      breathe_int_q  <= bdlec_pkg::BreatheIntRst;
      breathe_step_q <= bdlec_pkg::BreatheStepRst;
      blink_int_q    <= bdlec_pkg::BlinkIntRst;
      red_color_q    <= bdlec_pkg::RedColorRst;
      green_color_q  <= bdlec_pkg::GreenColorRst;
      flash_color_q  <= bdlec_pkg::FlashColorRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bdlec_pkg::REG_DEBOUNCE:     debounce_q     <= cfg_data_i[9:0];
        bdlec_pkg::REG_BREATHE_INT:  breathe_int_q  <= cfg_data_i[9:0];
        bdlec_pkg::REG_BREATHE_STEP: breathe_step_q <= cfg_data_i[7:0];
        bdlec_pkg::REG_BLINK_INT:    blink_int_q    <= cfg_data_i[12:0];
        bdlec_pkg::REG_RED_COLOR:    red_color_q    <= cfg_data_i;
        bdlec_pkg::REG_GREEN_COLOR:  green_color_q  <= cfg_data_i;
        bdlec_pkg::REG_FLASH_COLOR:  flash_color_q  <= cfg_data_i;
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake
  // ---------------------------------------------------------------------
  logic s1_valid_q;
  s1_t  s1_q, s1_d;
  logic out_ld, s1_free, in_fire;

  assign out_ld     = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign s1_free    = !s1_valid_q || out_ld;
  assign in_stall_o = !s1_free;
  assign in_fire    = in_valid_i && s1_free;

  // ---------------------------------------------------------------------
  // Stage one: debounce, effect step, mode priority
  // ---------------------------------------------------------------------
  logic [6:0]                   deb_q, deb_d, last_q;
  logic [bdlec_pkg::QuietW-1:0] cnt_q [bdlec_pkg::NumBtn];
  logic [bdlec_pkg::QuietW-1:0] cnt_d [bdlec_pkg::NumBtn];
  bdlec_pkg::mode_e             mode_q, mode_d;
  logic [bdlec_pkg::SinceW-1:0] since_q, since_d, since_inc;
  logic [7:0]                   bright_q, bright_d, gpeak_q, gpeak_d;
  logic                         dir_q, dir_d, phase_q, phase_d;
  logic                         first_done_q, first_done_d;
  logic                         all_seen_q, all_seen_d, rst_seen_q, rst_seen_d;

  logic [7:0]        peak, bnew;
  logic              dnew;
  logic signed [9:0] bsum;
  logic [6:0]        pressed;
  logic [2:0]        count;

  always_comb begin
    deb_d        = deb_q;
    mode_d       = mode_q;
    bright_d     = bright_q;
    dir_d        = dir_q;
    phase_d      = phase_q;
    gpeak_d      = gpeak_q;
    first_done_d = first_done_q;
    all_seen_d   = all_seen_q;
    rst_seen_d   = rst_seen_q;
    s1_d         = '0;
    count        = '0;

    // per-button quiet-time counters
    for (int i = 0; i < bdlec_pkg::NumBtn; i++) begin
      if (raw_levels_i[i] != last_q[i]) begin
        cnt_d[i] = '0;
      end else if (cnt_q[i] != bdlec_pkg::QuietMax) begin
        cnt_d[i] = cnt_q[i] + 1'b1;
      end else begin
        cnt_d[i] = cnt_q[i];
      end
      if (cnt_d[i] > {1'b0, debounce_q}) begin
        deb_d[i] = raw_levels_i[i];
      end
    end

    since_inc = (since_q != bdlec_pkg::SinceMax) ? since_q + 1'b1 : since_q;
    since_d   = since_inc;

    // triangle-wave step; peak test wins over the floor test
    peak = (mode_q == bdlec_pkg::MODE_RED) ? bdlec_pkg::PeakFull : gpeak_q;
    if (dir_q) begin
      bsum = $signed({2'b00, bright_q}) + $signed({2'b00, breathe_step_q});
    end else begin
      bsum = $signed({2'b00, bright_q}) - $signed({2'b00, breathe_step_q});
    end
    if (bsum >= $signed({2'b00, peak})) begin
      bnew = peak;
      dnew = 1'b0;
    end else if (bsum <= 10'sd0) begin
      bnew = '0;
      dnew = 1'b1;
    end else begin
      bnew = bsum[7:0];
      dnew = dir_q;
    end

    case (mode_q)
      bdlec_pkg::MODE_RED, bdlec_pkg::MODE_GREEN: begin
        if (since_inc >= {3'd0, breathe_int_q}) begin
          since_d       = '0;
          bright_d      = bnew;
          dir_d         = dnew;
          s1_d.refresh  = 1'b1;
          s1_d.scaled   = 1'b1;
          s1_d.bright   = bnew;
          s1_d.rgb      = (mode_q == bdlec_pkg::MODE_RED) ? red_color_q : green_color_q;
        end
      end
      bdlec_pkg::MODE_FLASH: begin
        if (since_inc >= blink_int_q) begin
          since_d      = '0;
          s1_d.refresh = 1'b1;
          s1_d.rgb     = phase_q ? flash_color_q : '0;
          phase_d      = ~phase_q;
        end
      end
      default: begin
        // unused mode code: push dark every tick
        s1_d.refresh = 1'b1;
      end
    endcase

    // priority chain over the debounced buttons
    pressed = ~deb_d;
    if (!first_done_q && (pressed[bdlec_pkg::ResetBit-1:0] != '0)) begin
      s1_d.ev_first = 1'b1;
      first_done_d  = 1'b1;
    end
    for (int i = 1; i <= bdlec_pkg::GroupCount; i++) begin
      count = count + {2'b00, pressed[i]};
    end

    if (pressed[0]) begin
      mode_d     = bdlec_pkg::MODE_FLASH;
      all_seen_d = 1'b0;
      rst_seen_d = 1'b0;
    end else if (pressed[bdlec_pkg::ResetBit]) begin
      mode_d = bdlec_pkg::MODE_RED;
      if (!rst_seen_q) begin
        s1_d.ev_reset = 1'b1;
        rst_seen_d    = 1'b1;
      end
      all_seen_d = 1'b0;
    end else if (count != '0) begin
      gpeak_d = 8'(count * bdlec_pkg::PeakPerButton);
      mode_d  = bdlec_pkg::MODE_GREEN;
      if ((count == 3'(bdlec_pkg::GroupCount)) && !all_seen_q) begin
        s1_d.ev_all = 1'b1;
      end
      all_seen_d = (count == 3'(bdlec_pkg::GroupCount));
      rst_seen_d = 1'b0;
    end else begin
      mode_d     = bdlec_pkg::MODE_RED;
      gpeak_d    = '0;
      all_seen_d = 1'b0;
      rst_seen_d = 1'b0;
    end

    // a mode change restarts the effect timing and the wave
    if (mode_d != mode_q) begin
      since_d  = '0;
      bright_d = '0;
      dir_d    = 1'b1;
    end

    s1_d.pressed = pressed;
    s1_d.mode    = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q        <= '1;
      last_q       <= '1;
      for (int i = 0; i < bdlec_pkg::NumBtn; i++) begin
        cnt_q[i] <= bdlec_pkg::QuietMax;
      end
      mode_q       <= bdlec_pkg::MODE_RED;
      since_q      <= bdlec_pkg::SinceMax;
      bright_q     <= '0;
      dir_q        <= 1'b1;
      phase_q      <= 1'b0;
      gpeak_q      <= '0;
      first_done_q <= 1'b0;
      all_seen_q   <= 1'b0;
      rst_seen_q   <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        deb_q        <= deb_d;
        last_q       <= raw_levels_i;
        for (int i = 0; i < bdlec_pkg::NumBtn; i++) begin
          cnt_q[i] <= cnt_d[i];
        end
        mode_q       <= mode_d;
        since_q      <= since_d;
        bright_q     <= bright_d;
        dir_q        <= dir_d;
        phase_q      <= phase_d;
        gpeak_q      <= gpeak_d;
        first_done_q <= first_done_d;
        all_seen_q   <= all_seen_d;
        rst_seen_q   <= rst_seen_d;
        s1_valid_q   <= 1'b1;
      end else if (out_ld) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage two: colour scaling and output register
  // ---------------------------------------------------------------------
  logic [23:0] strip_q, strip_d;

  always_comb begin
    strip_d = strip_q;  // idle tick: repeat last pushed colour
    if (s1_q.refresh) begin
      if (s1_q.scaled) begin
        strip_d = {scale_chan(s1_q.rgb[23:16], s1_q.bright),
                   scale_chan(s1_q.rgb[15:8],  s1_q.bright),
                   scale_chan(s1_q.rgb[7:0],   s1_q.bright)};
      end else begin
        strip_d = s1_q.rgb;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      strip_q     <= '0;
    end else begin
      if (out_ld) begin
        out_valid_o <= 1'b1;
        strip_q     <= strip_d;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      strip_refresh_o     <= s1_q.refresh;
      pressed_mask_o      <= s1_q.pressed;
      effect_mode_o       <= s1_q.mode;
      reset_event_o       <= s1_q.ev_reset;
      all_group_event_o   <= s1_q.ev_all;
      first_press_event_o <= s1_q.ev_first;
    end
  end

  assign led_red_o   = strip_q[23:16];
  assign led_green_o = strip_q[15:8];
  assign led_blue_o  = strip_q[7:0];

`ifndef ASSERT_OFF
  // a stage-one item waiting on the output holds its payload
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_ld |=> $stable(s1_q))
    else $error("stage-one payload changed while waiting");

  // a mode change restarts timing and the breathing wave
  a_mode_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (mode_d != mode_q) |=> (since_q == '0) && (bright_q == '0) && dir_q)
    else $error("mode change did not restart the effect");

  // the reset event only comes with red breathing selected
  a_reset_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_event_o |-> effect_mode_o == bdlec_pkg::MODE_RED)
    else $error("reset event without red breathing");

  // the all-group event needs all five group buttons pressed
  a_all_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_group_event_o |-> pressed_mask_o[5:1] == 5'h1F)
    else $error("all-group event with a group button released");
`endif

endmodule

`default_nettype wire

@@ tb/button_driven_led_effect_controller_test.sv @@
// Self-checking testbench for button_driven_led_effect_controller.
// Holds the tick driver, result monitor, an in-bench predictor and config writes.
// Depends on bdlec_pkg and the RTL top level only.
`default_nettype none

module button_driven_led_effect_controller_test;

  localparam int unsigned TimeoutCycles = 400000;

  // One result of one tick, as the block presents it.
  typedef struct packed {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             refresh;
    logic [6:0]       pressed;
    bdlec_pkg::mode_e mode;
    logic             ev_reset;
    logic             ev_all;
    logic             ev_first;
  } strip_out_t;

  // DUT connections
  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [6:0]  raw_levels_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  led_red_o;
  logic [7:0]  led_green_o;
  logic [7:0]  led_blue_o;
  logic        strip_refresh_o;
  logic [6:0]  pressed_mask_o;
  logic [1:0]  effect_mode_o;
  logic        reset_event_o;
  logic        all_group_event_o;
  logic        first_press_event_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [bdlec_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [bdlec_pkg::CfgDataW-1:0] cfg_data_i;

  // Stimulus and scoreboard storage
  logic [6:0]  tick_q[$];          // ticks waiting for their input transfer
  strip_out_t  pending_strips[$];  // predicted results, oldest first
  bit          tick_taken;         // set at the edge where a tick transfer happened
  bit          idle_en;            // random gaps and stalls enabled
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned fault_cnt;
  strip_out_t  seen_out;

  // Predictor copy of the configuration registers
  logic [9:0]  cfg_debounce;
  logic [9:0]  cfg_breathe_int;
  logic [7:0]  cfg_step;
  logic [12:0] cfg_blink;
  logic [23:0] cfg_red;
  logic [23:0] cfg_green;
  logic [23:0] cfg_flash;

  // Predictor copy of the block state
  logic [6:0]                   deb_lvl;
  logic [6:0]                   last_smp;
  logic [bdlec_pkg::QuietW-1:0] quiet [bdlec_pkg::NumBtn];
  bdlec_pkg::mode_e             cur_mode;
  logic [bdlec_pkg::SinceW-1:0] since;
  logic [7:0]                   bright;
  logic                         rising;
  logic                         phase;
  logic [7:0]                   grp_peak;
  logic                         first_done;
  logic                         all_seen;
  logic                         rst_seen;
  logic [23:0]                  color;

  button_driven_led_effect_controller u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .raw_levels_i        (raw_levels_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .led_red_o           (led_red_o),
    .led_green_o         (led_green_o),
    .led_blue_o          (led_blue_o),
    .strip_refresh_o     (strip_refresh_o),
    .pressed_mask_o      (pressed_mask_o),
    .effect_mode_o       (effect_mode_o),
    .reset_event_o       (reset_event_o),
    .all_group_event_o   (all_group_event_o),
    .first_press_event_o (first_press_event_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Channel times brightness over full scale, truncated.
  function automatic logic [7:0] dim(input logic [7:0] chan, input logic [7:0] lvl);
    int unsigned prod;
    prod = chan;
    prod = prod * lvl;
    return 8'(prod / 255);
  endfunction

  // A mode change restarts the effect timer and the wave; flash phase is kept.
  function automatic void pick_mode(input bdlec_pkg::mode_e m);
    if (cur_mode != m) begin
      cur_mode = m;
      since    = '0;
      bright   = '0;
      rising   = 1'b1;
    end
  endfunction

  // Advances the predicted state by one tick and returns the expected result.
  function automatic strip_out_t advance_tick(input logic [6:0] raw);
    strip_out_t  r;
    logic [6:0]  pressed;
    logic [7:0]  peak;
    logic [23:0] base;
    int          lvl;
    int          pk;
    int          st;
    int unsigned grp;
    int          b;
    r = '0;

    // Debounce: any change restarts the bit's quiet count.
    for (b = 0; b < bdlec_pkg::NumBtn; b++) begin
      if (raw[b] != last_smp[b]) quiet[b] = '0;
      else if (quiet[b] != bdlec_pkg::QuietMax) quiet[b] = quiet[b] + 1'b1;
      if (quiet[b] > cfg_debounce) deb_lvl[b] = raw[b];
    end
    last_smp = raw;

    // Effect step uses the mode held from the previous tick.
    if (since != bdlec_pkg::SinceMax) since = since + 1'b1;
    case (cur_mode)
      bdlec_pkg::MODE_RED, bdlec_pkg::MODE_GREEN: begin
        if (since >= cfg_breathe_int) begin
          since = '0;
          peak  = (cur_mode == bdlec_pkg::MODE_RED) ? bdlec_pkg::PeakFull : grp_peak;
          base  = (cur_mode == bdlec_pkg::MODE_RED) ? cfg_red : cfg_green;
          lvl   = bright;
          pk    = peak;
          st    = cfg_step;
          lvl   = rising ? lvl + st : lvl - st;
          // peak clamp is tested before the floor clamp
          if (lvl >= pk) begin
            lvl    = pk;
            rising = 1'b0;
          end else if (lvl <= 0) begin
            lvl    = 0;
            rising = 1'b1;
          end
          bright    = lvl[7:0];
          color     = {dim(base[23:16], bright), dim(base[15:8], bright),
                       dim(base[7:0], bright)};
          r.refresh = 1'b1;
        end
      end
      bdlec_pkg::MODE_FLASH: begin
        if (since >= cfg_blink) begin
          since     = '0;
          color     = phase ? cfg_flash : '0;
          phase     = ~phase;
          r.refresh = 1'b1;
        end
      end
      default: begin
        color     = '0;
        r.refresh = 1'b1;
      end
    endcase

    pressed = ~deb_lvl;
    if (!first_done && (|pressed[bdlec_pkg::ResetBit-1:0])) begin
      r.ev_first = 1'b1;
      first_done = 1'b1;
    end
    grp = $countones(pressed[bdlec_pkg::GroupCount:1]);

    // Priority: warning, then reset, then group, then nothing pressed.
    if (pressed[0]) begin
      pick_mode(bdlec_pkg::MODE_FLASH);
      all_seen = 1'b0;
      rst_seen = 1'b0;
    end else if (pressed[bdlec_pkg::ResetBit]) begin
      pick_mode(bdlec_pkg::MODE_RED);
      if (!rst_seen) begin
        r.ev_reset = 1'b1;
        rst_seen   = 1'b1;
      end
      all_seen = 1'b0;
    end else if (grp > 0) begin
      grp_peak = 8'(grp * bdlec_pkg::PeakPerButton);
      pick_mode(bdlec_pkg::MODE_GREEN);
      if (grp == bdlec_pkg::GroupCount && !all_seen) r.ev_all = 1'b1;
      all_seen = (grp == bdlec_pkg::GroupCount);
      rst_seen = 1'b0;
    end else begin
      pick_mode(bdlec_pkg::MODE_RED);
      grp_peak = '0;
      all_seen = 1'b0;
      rst_seen = 1'b0;
    end

    r.red     = color[23:16];
    r.green   = color[15:8];
    r.blue    = color[7:0];
    r.pressed = pressed;
    r.mode    = cur_mode;
    return r;
  endfunction

  function automatic string show(input strip_out_t s);
    return $sformatf({"rgb=%02h%02h%02h refresh=%0b pressed=%02h mode=%0d ",
                      "ev(rst,all,first)=%0b%0b%0b"},
                     s.red, s.green, s.blue, s.refresh, s.pressed, s.mode,
                     s.ev_reset, s.ev_all, s.ev_first);
  endfunction

  // ---------------------------------------------------------------------------
  // Tick driver: presents the head of tick_q; a stalled transfer holds its
  // payload. Idle gaps of random length follow a transfer at random.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (in_valid_i && !tick_taken) begin
      // stalled: keep valid and payload as they are
    end else if (gap_left != 0) begin
      gap_left   = gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (tick_q.size() != 0) begin
      in_valid_i   <= 1'b1;
      raw_levels_i <= tick_q[0];
      if (idle_en && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 9);
    end else begin
      in_valid_i <= 1'b0;
    end
    tick_taken = 1'b0;
  end

  // Receiver back-pressure: stall bursts of random length.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (idle_en && rst_ni && $urandom_range(0, 5) == 0) begin
      stall_left  = $urandom_range(0, 8);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Input transfer: predict the result right away, config is stable here.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_strips.push_back(advance_tick(raw_levels_i));
      void'(tick_q.pop_front());
      tick_taken = 1'b1;
    end
  end

  // Output transfer: compare field by field with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_out.red      = led_red_o;
      seen_out.green    = led_green_o;
      seen_out.blue     = led_blue_o;
      seen_out.refresh  = strip_refresh_o;
      seen_out.pressed  = pressed_mask_o;
      seen_out.mode     = bdlec_pkg::mode_e'(effect_mode_o);
      seen_out.ev_reset = reset_event_o;
      seen_out.ev_all   = all_group_event_o;
      seen_out.ev_first = first_press_event_o;
      if (pending_strips.size() == 0) begin
        fault_cnt = fault_cnt + 1;
        if (fault_cnt <= 10) $display("unexpected result: %s", show(seen_out));
      end else begin
        if (seen_out.red !== pending_strips[0].red ||
            seen_out.green !== pending_strips[0].green ||
            seen_out.blue !== pending_strips[0].blue ||
            seen_out.refresh !== pending_strips[0].refresh ||
            seen_out.pressed !== pending_strips[0].pressed ||
            seen_out.mode !== pending_strips[0].mode ||
            seen_out.ev_reset !== pending_strips[0].ev_reset ||
            seen_out.ev_all !== pending_strips[0].ev_all ||
            seen_out.ev_first !== pending_strips[0].ev_first) begin
          fault_cnt = fault_cnt + 1;
          if (fault_cnt <= 10) begin
            $display("mismatch at %0t", $realtime);
            $display("  expected %s", show(pending_strips[0]));
            $display("  actual   %s", show(seen_out));
          end
        end
        void'(pending_strips.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  task automatic hold_level(input logic [6:0] lvl, input int unsigned n);
    repeat (n) tick_q.push_back(lvl);
  endtask

  // Waits until every tick went in and every result came out, then lets the
  // two-stage pipeline settle before anything else happens.
  task automatic drain();
    while (tick_q.size() != 0 || pending_strips.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One config transfer; the mirror is updated at the accepting edge.
  task automatic write_reg(input bdlec_pkg::reg_idx_e idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      bdlec_pkg::REG_DEBOUNCE:     cfg_debounce    = val[9:0];
      bdlec_pkg::REG_BREATHE_INT:  cfg_breathe_int = val[9:0];
      bdlec_pkg::REG_BREATHE_STEP: cfg_step        = val[7:0];
      bdlec_pkg::REG_BLINK_INT:    cfg_blink       = val[12:0];
      bdlec_pkg::REG_RED_COLOR:    cfg_red         = val;
      bdlec_pkg::REG_GREEN_COLOR:  cfg_green       = val;
      bdlec_pkg::REG_FLASH_COLOR:  cfg_flash       = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [23:0] deb, input logic [23:0] bint,
                              input logic [23:0] stp, input logic [23:0] blink,
                              input logic [23:0] red, input logic [23:0] green,
                              input logic [23:0] flash);
    write_reg(bdlec_pkg::REG_DEBOUNCE, deb);
    write_reg(bdlec_pkg::REG_BREATHE_INT, bint);
    write_reg(bdlec_pkg::REG_BREATHE_STEP, stp);
    write_reg(bdlec_pkg::REG_BLINK_INT, blink);
    write_reg(bdlec_pkg::REG_RED_COLOR, red);
    write_reg(bdlec_pkg::REG_GREEN_COLOR, green);
    write_reg(bdlec_pkg::REG_FLASH_COLOR, flash);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Button activity: levels mostly held past the debounce time so they get
  // accepted, some held too briefly, and sparse single-tick contact bounce.
  task automatic push_presses(input int unsigned count);
    logic [6:0]  lvl;
    int unsigned hold;
    int unsigned k;
    int unsigned pushed;
    pushed = 0;
    while (pushed < count) begin
      case ($urandom_range(0, 9))
        0, 1:    lvl = 7'h7F;                                        // all released
        2, 3, 4: lvl = {1'b1, ~5'($urandom_range(1, 31)), 1'b1};     // some group buttons
        5:       lvl = 7'h41;                                        // whole group
        6:       lvl = {1'b0, 5'($urandom), 1'b1};                   // reset, group random
        7:       lvl = {6'($urandom), 1'b0};                         // warning
        default: lvl = 7'($urandom);
      endcase
      if ($urandom_range(0, 5) == 0) hold = $urandom_range(1, cfg_debounce + 1);
      else hold = cfg_debounce + 1 + $urandom_range(0, 12);
      for (k = 0; k < hold && pushed < count; k++) begin
        if ($urandom_range(0, 29) == 0) tick_q.push_back(7'($urandom));
        else tick_q.push_back(lvl);
        pushed++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned p;
    int unsigned b;
    logic [23:0] stp;
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] flash;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    raw_levels_i = 7'h7F;
    out_stall_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = bdlec_pkg::REG_DEBOUNCE;
    cfg_data_i   = '0;
    tick_taken   = 1'b0;
    idle_en      = 1'b1;
    gap_left     = 0;
    stall_left   = 0;
    fault_cnt    = 0;

    cfg_debounce    = bdlec_pkg::DebounceRst;
    cfg_breathe_int = bdlec_pkg::BreatheIntRst;
    cfg_step        = bdlec_pkg::BreatheStepRst;
    cfg_blink       = bdlec_pkg::BlinkIntRst;
    cfg_red         = bdlec_pkg::RedColorRst;
    cfg_green       = bdlec_pkg::GreenColorRst;
    cfg_flash       = bdlec_pkg::FlashColorRst;

    deb_lvl  = 7'h7F;
    last_smp = 7'h7F;
    for (b = 0; b < bdlec_pkg::NumBtn; b++) quiet[b] = bdlec_pkg::QuietMax;
    cur_mode   = bdlec_pkg::MODE_RED;
    since      = bdlec_pkg::SinceMax;
    bright     = '0;
    rising     = 1'b1;
    phase      = 1'b0;
    grp_peak   = '0;
    first_done = 1'b0;
    all_seen   = 1'b0;
    rst_seen   = 1'b0;
    color      = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration: saturated effect timer steps red at once, a
    // one-tick warning blip is far too short to be accepted.
    hold_level(7'h7F, 1);
    hold_level(7'h7E, 1);
    hold_level(7'h7F, 1);
    drain();

    // Directed: zero debounce, steps every tick at full size so the wave
    // clamps at both ends, flash toggles every tick.
    program_regs(24'd0, 24'd1, 24'd255, 24'd1, 24'hFFFFFF, 24'h0180FF, 24'h7F00FE);
    hold_level(7'h7F, 2);
    hold_level(7'h7D, 3);   // one group button: first press, green peak 51
    hold_level(7'h41, 3);   // all five group buttons: group event, peak 255
    hold_level(7'h3F, 3);   // reset alone: reset event, back to red
    hold_level(7'h01, 2);   // reset outranks the group
    hold_level(7'h7E, 3);   // warning: flashing
    hold_level(7'h00, 2);   // everything pressed, warning still wins
    hold_level(7'h7F, 2);
    drain();

    // Random phases. Phases 1..3 hold one of the slowest settings and stay
    // short; the rest run fast timings so buttons settle and effects step
    // often. Each phase boundary also makes the sender wait for every result.
    for (p = 0; p < 7; p++) begin
      case ($urandom_range(0, 2))
        0:       stp = 24'd1;
        1:       stp = 24'd255;
        default: stp = $urandom_range(1, 255);
      endcase
      red   = 24'($urandom);
      green = 24'($urandom);
      flash = 24'($urandom);
      if (p == 4) begin
        red   = 24'h000000;
        green = 24'hFFFFFF;
        flash = 24'hFFFFFF;
      end else if (p == 5) begin
        red   = 24'hFFFFFF;
        green = 24'h000000;
        flash = 24'h000000;
      end
      program_regs((p == 1) ? 24'd1000 : 24'($urandom_range(0, 4)),
                   (p == 2) ? 24'd1000 : 24'($urandom_range(1, 5)),
                   stp,
                   (p == 3) ? 24'd5000 : 24'($urandom_range(1, 6)),
                   red, green, flash);
      // final stretch runs with no gaps and no stalls
      if (p == 6) idle_en = 1'b0;
      push_presses((p >= 1 && p <= 3) ? 40 : 250);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (fault_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TimeoutCycles * 10);
    $display("timeout with %0d results outstanding", pending_strips.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/bdlec_pkg.sv
rtl/button_driven_led_effect_controller.sv
tb/button_driven_led_effect_controller_test.sv
